/* rtl/tng_pkg.sv */
package tng_pkg;

  // Fixed field widths
  localparam int WHITE_W  = 16;
  localparam int ROWS_W   = 40;
  localparam int MODE_W   = 2;
  localparam int REG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int KEY_W    = 5;
  localparam int MUL_AW   = 18;   // operand A of the shared multiplier
  localparam int WHITE_VW = 21;   // signed range of amplitude * white

  // Parameter defaults
  localparam int NUM_ROWS_DEF     = 5;
  localparam int ROW_SPAN_DEF     = 25;
  localparam int SAMPLE_WIDTH_DEF = 24;

  localparam int MAX_SUM_RESET = 90;

  // Tint modes
  localparam logic [MODE_W-1:0] MODE_WHITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BROWN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PINK  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TINT_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BROWN_ALPHA = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BROWN_GAIN  = 2'd3;

  // Reset values
  localparam logic [MODE_W-1:0] TINT_MODE_RST   = MODE_WHITE;
  localparam logic [REG_W-1:0]  AMPLITUDE_RST   = 16'd4096;
  localparam logic [REG_W-1:0]  BROWN_ALPHA_RST = 16'd921;
  localparam logic [REG_W-1:0]  BROWN_GAIN_RST  = 16'd25395;

  typedef struct packed {
    logic [MODE_W-1:0] tint_mode;
    logic [REG_W-1:0]  amplitude;
    logic [REG_W-1:0]  brown_alpha;
    logic [REG_W-1:0]  brown_gain;
  } tng_cfg_t;

  // byte mod span by eight compare-subtract steps
  function automatic logic [7:0] row_mod(input logic [7:0] b, input logic [7:0] span);
    logic [15:0] r;
    logic [15:0] t;
    r = {8'd0, b};
    for (int k = 7; k >= 0; k--) begin
      t = {8'd0, span} << k;
      if (r >= t) begin
        r = r - t;
      end
    end
    return r[7:0];
  endfunction

endpackage

/* rtl/tng_cfg.sv */
module tng_cfg import tng_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output tng_cfg_t             cfg
);

  tng_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tint_mode   <= TINT_MODE_RST;
      cfg_r.amplitude   <= AMPLITUDE_RST;
      cfg_r.brown_alpha <= BROWN_ALPHA_RST;
      cfg_r.brown_gain  <= BROWN_GAIN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TINT_MODE:   cfg_r.tint_mode   <= cfg_data[MODE_W-1:0];
        REG_AMPLITUDE:   cfg_r.amplitude   <= cfg_data;
        REG_BROWN_ALPHA: cfg_r.brown_alpha <= cfg_data;
        REG_BROWN_GAIN:  cfg_r.brown_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/tng_mul.sv */
module tng_mul import tng_pkg::*; #(
  parameter int BW = 25
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [MUL_AW-1:0]       op_a,
  input  logic signed [BW-1:0]           op_b,
  output logic signed [MUL_AW+BW-1:0]    prod
);

  logic signed [MUL_AW+BW-1:0] prod_r;

  assign prod = prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

endmodule

/* rtl/tng_div.sv */
module tng_div import tng_pkg::*; #(
  parameter int NW = 31,   // dividend / quotient width
  parameter int DW = 11    // divisor width
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] dvs_r;
  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   diff;

  assign trial    = {rem_r, quo_r[NW-1]};
  assign ge       = trial >= {1'b0, dvs_r};
  assign diff     = trial - {1'b0, dvs_r};
  assign busy     = busy_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

endmodule

/* rtl/tinted_noise_generator.sv */
// Tinted noise generator: one signed Q8.15 noise sample per input request.
// Input channel (in_valid / in_stall): a 16-bit uniform value and one random
// byte per pink row. Result channel (out_valid / out_stall): the sample and a
// clip flag. cfg_* writes tint_mode, amplitude, brown_alpha, brown_gain; it is
// always ready and must only be written while no request is in flight.
// A request is worked on through one shared multiplier (and, in pink mode, a
// bit-serial divider) under a small sequencer; in_stall is high meanwhile.
// The pink divider is QW = row-sum width + 21 bits wide (28 at defaults).
// The pink row pass takes one row per cycle; the divider one bit per cycle.
// A new request is accepted as soon as the sequencer is idle, even while
// the previous result still waits in the output register; if the receiver
// stalls, the finished sample parks in the sequencer until that register
// frees. Reset (synchronous, rst_n low) restores register defaults, clears
// the pink key, rows and brown filter memory, and sets the running row-sum
// maximum to 90.
module tinted_noise_generator import tng_pkg::*; #(
  parameter int NUM_ROWS     = NUM_ROWS_DEF,
  parameter int ROW_SPAN     = ROW_SPAN_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [WHITE_W-1:0]             in_white_random,
  input  logic [ROWS_W-1:0]              in_row_randoms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample,
  output logic                           out_clipped,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [REG_W-1:0]               cfg_data
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int MB     = ((SW > WHITE_VW) ? SW : WHITE_VW) + 1;  // multiplier B width
  localparam int PW     = MUL_AW + MB;                            // product width
  localparam int AW     = PW + 1;                                 // working width
  localparam int RVW    = $clog2(ROW_SPAN);
  localparam int SUMX   = NUM_ROWS * (ROW_SPAN - 1);
  localparam int SUMW   = ($clog2(SUMX + 1) > 7) ? $clog2(SUMX + 1) : 7;
  localparam int QW     = SUMW + 21;                              // divider width
  localparam int ROW_IW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

  localparam logic signed [AW-1:0] SAT_HI = {{(AW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

  // sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_WMUL      = 4'd1;
  localparam logic [3:0] S_WRND      = 4'd2;
  localparam logic [3:0] S_BR_A      = 4'd3;
  localparam logic [3:0] S_BR_B      = 4'd4;
  localparam logic [3:0] S_BR_M      = 4'd5;
  localparam logic [3:0] S_BR_G      = 4'd6;
  localparam logic [3:0] S_BR_RND    = 4'd7;
  localparam logic [3:0] S_PK_ROW    = 4'd8;
  localparam logic [3:0] S_PK_MAX    = 4'd9;
  localparam logic [3:0] S_PK_MUL    = 4'd10;
  localparam logic [3:0] S_PK_DIVSET = 4'd11;
  localparam logic [3:0] S_PK_DIV    = 4'd12;
  localparam logic [3:0] S_OUT       = 4'd13;

  // round to nearest (ties up) after an arithmetic right shift
  function automatic logic signed [AW-1:0] rnd_fn(input logic signed [AW-1:0] x,
                                                  input int sh);
    logic signed [AW-1:0] h;
    logic signed [AW-1:0] s;
    h = $signed(AW'(1) << (sh - 1));
    s = x + h;
    return s >>> sh;
  endfunction

  // clamp to SW bits; top bit is the clip flag
  function automatic logic [SW:0] sat_fn(input logic signed [AW-1:0] x);
    logic [SW:0] r;
    if (x > SAT_HI) begin
      r = {1'b1, SAT_HI[SW-1:0]};
    end else if (x < SAT_LO) begin
      r = {1'b1, SAT_LO[SW-1:0]};
    end else begin
      r = {1'b0, x[SW-1:0]};
    end
    return r;
  endfunction

  tng_cfg_t cfg;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // request payload
  logic [WHITE_W-1:0] white_r;
  logic [ROWS_W-1:0]  rows_r;

  // pink state
  logic [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]  diff_r;
  logic [RVW-1:0]    row_r [NUM_ROWS];
  logic [ROW_IW-1:0] row_idx_r;
  logic [SUMW-1:0]   sum_r;
  logic [SUMW-1:0]   max_r;

  // brown filter memory
  logic signed [SW-1:0] brown_mem_r;

  // working value and pink sign
  logic signed [AW-1:0] res_r;
  logic                 neg_r;

  // result register
  logic                 out_valid_r;
  logic signed [SW-1:0] out_sample_r;
  logic                 out_clipped_r;

  logic                        in_acc;
  logic                        out_load;
  logic                        mul_en;
  logic signed [MUL_AW-1:0]    mul_a;
  logic signed [MB-1:0]        mul_b;
  logic signed [PW-1:0]        prod;
  logic signed [AW-1:0]        pext;
  logic signed [AW-1:0]        brown_sum;
  logic [SW:0]                 brown_sat;
  logic [SW:0]                 out_sat;
  logic [7:0]                  row_byte;
  logic [RVW-1:0]              row_new;
  logic [SUMW-1:0]             max_new;
  logic signed [AW-1:0]        nsum;
  logic [QW-1:0]               div_dividend;
  logic                        div_start;
  logic                        div_busy;
  logic [QW-1:0]               div_quo;
  logic signed [AW-1:0]        qx;

  tng_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tng_mul #(.BW(MB)) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  tng_div #(.NW(QW), .DW(SUMW + 1)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  ({max_r, 1'b0}),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign in_stall    = (state_r != S_IDLE);
  assign in_acc      = in_valid && (state_r == S_IDLE);
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign out_valid   = out_valid_r;
  assign out_sample  = out_sample_r;
  assign out_clipped = out_clipped_r;

  assign pext = $signed({prod[PW-1], prod});

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_WMUL: begin
        mul_a = $signed({2'b00, cfg.amplitude});
        // r - 32768 is r with its top bit flipped, read as signed
        mul_b = $signed({{(MB - WHITE_W){~white_r[WHITE_W-1]}}, ~white_r[WHITE_W-1],
                         white_r[WHITE_W-2:0]});
      end
      S_BR_A: begin
        mul_a = $signed({2'b00, cfg.brown_alpha});
        mul_b = res_r[MB-1:0];
      end
      S_BR_B: begin
        mul_a = $signed({1'b0, 17'(17'h10000 - {1'b0, cfg.brown_alpha})});
        mul_b = $signed({{(MB - SW){brown_mem_r[SW-1]}}, brown_mem_r});
      end
      S_BR_G: begin
        mul_a = $signed({2'b00, cfg.brown_gain});
        mul_b = $signed({{(MB - SW){brown_mem_r[SW-1]}}, brown_mem_r});
      end
      S_PK_MUL: begin
        mul_a = $signed({2'b00, cfg.amplitude});
        mul_b = res_r[MB-1:0];
      end
      default: mul_en = 1'b0;
    endcase
  end

  // brown: m' = (alpha*w + (1-alpha)*m) / 2^16, rounded and clamped
  assign brown_sum = res_r + pext;
  assign brown_sat = sat_fn(rnd_fn(brown_sum, 16));

  // pink row update
  assign row_byte = rows_r[{row_idx_r, 3'b000} +: 8];
  assign row_new  = diff_r[row_idx_r] ? RVW'(row_mod(row_byte, 8'(ROW_SPAN)))
                                      : row_r[row_idx_r];
  assign max_new  = (sum_r > max_r) ? sum_r : max_r;

  // pink divide: floor((2*num + max) / (2*max)), num = amp * (2sum - max) * 8
  assign nsum         = $signed({pext[AW-5:0], 4'b0000})
                      + $signed({{(AW - SUMW){1'b0}}, max_r});
  assign div_dividend = nsum[AW-1] ? QW'(~nsum) : QW'(nsum);
  assign div_start    = (state_r == S_PK_DIVSET);
  assign qx           = $signed({{(AW - QW){1'b0}}, div_quo});

  assign out_sat = sat_fn(res_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (cfg.tint_mode == MODE_PINK) ? S_PK_ROW : S_WMUL;
        end
      end
      S_WMUL:   state_nxt = S_WRND;
      S_WRND:   state_nxt = (cfg.tint_mode == MODE_BROWN) ? S_BR_A : S_OUT;
      S_BR_A:   state_nxt = S_BR_B;
      S_BR_B:   state_nxt = S_BR_M;
      S_BR_M:   state_nxt = S_BR_G;
      S_BR_G:   state_nxt = S_BR_RND;
      S_BR_RND: state_nxt = S_OUT;
      S_PK_ROW: begin
        if (row_idx_r == ROW_IW'(NUM_ROWS - 1)) begin
          state_nxt = S_PK_MAX;
        end
      end
      S_PK_MAX:    state_nxt = S_PK_MUL;
      S_PK_MUL:    state_nxt = S_PK_DIVSET;
      S_PK_DIVSET: state_nxt = S_PK_DIV;
      S_PK_DIV: begin
        if (!div_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      key_r       <= '0;
      max_r       <= SUMW'(MAX_SUM_RESET);
      brown_mem_r <= '0;
      row_idx_r   <= '0;
      sum_r       <= '0;
      for (int i = 0; i < NUM_ROWS; i++) begin
        row_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      // key advances once per pink request, wraps at 31
      if (in_acc && (cfg.tint_mode == MODE_PINK)) begin
        key_r     <= key_r + 1'b1;
        row_idx_r <= '0;
        sum_r     <= '0;
      end

      if (state_r == S_PK_ROW) begin
        row_r[row_idx_r] <= row_new;
        sum_r            <= sum_r + SUMW'(row_new);
        row_idx_r        <= row_idx_r + 1'b1;
      end

      if (state_r == S_PK_MAX) begin
        max_r <= max_new;
      end

      if (state_r == S_BR_M) begin
        brown_mem_r <= brown_sat[SW-1:0];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      white_r <= in_white_random;
      rows_r  <= in_row_randoms;
      diff_r  <= key_r ^ (key_r + 1'b1);
    end

    case (state_r)
      S_WRND:   res_r <= rnd_fn(pext, 12);
      S_BR_B:   res_r <= pext;                     // alpha * w, held for the add
      S_BR_RND: res_r <= rnd_fn(pext, 12);
      S_PK_MAX: res_r <= $signed({{(AW - SUMW - 1){1'b0}}, sum_r, 1'b0})
                       - $signed({{(AW - SUMW){1'b0}}, max_new});
      S_PK_DIVSET: neg_r <= nsum[AW-1];
      S_PK_DIV: begin
        if (!div_busy) begin
          res_r <= neg_r ? ~qx : qx;               // floor for a negative dividend
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_sample_r  <= out_sat[SW-1:0];
      out_clipped_r <= out_sat[SW];
    end
  end

endmodule
